[rtl/rhsc_pkg.sv]
// Shared types, codes and reset values for the repetition and set counter.
package rhsc_pkg;

   // Command codes carried in the func field of an input beat.
   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_START  = 2'd1;
   localparam logic [1:0] FUNC_STOP   = 2'd2;

   // Pace classification of a finished repetition.
   localparam logic [1:0] PACE_OK   = 2'd0;
   localparam logic [1:0] PACE_FAST = 2'd1;
   localparam logic [1:0] PACE_SLOW = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_DOWN_LEVEL    = 3'd0;
   localparam logic [2:0] CSR_UP_LEVEL      = 3'd1;
   localparam logic [2:0] CSR_FAST_LIMIT_MS = 3'd2;
   localparam logic [2:0] CSR_SLOW_LIMIT_MS = 3'd3;
   localparam logic [2:0] CSR_SET_LENGTH    = 3'd4;
   localparam logic [2:0] CSR_GOAL_SETS     = 3'd5;

   // Configuration reset values.
   localparam logic [15:0] RST_DOWN_LEVEL    = 16'd160;
   localparam logic [15:0] RST_UP_LEVEL      = 16'd320;
   localparam logic [15:0] RST_FAST_LIMIT_MS = 16'd500;
   localparam logic [15:0] RST_SLOW_LIMIT_MS = 16'd3000;
   localparam logic [7:0]  RST_SET_LENGTH    = 8'd10;
   localparam logic [7:0]  RST_GOAL_SETS     = 8'd3;

   localparam logic [7:0]  CNT8_MAX  = 8'hFF;
   localparam logic [15:0] CNT16_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] down_level;
      logic [15:0] up_level;
      logic [15:0] fast_limit_ms;
      logic [15:0] slow_limit_ms;
      logic [7:0]  set_length;
      logic [7:0]  goal_sets;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] distance;
      logic        distance_valid;
      logic [31:0] time_ms;
   } item_type;

   typedef struct packed {
      logic        is_down;
      logic [31:0] down_time;
      logic [7:0]  rep_count;
      logic [7:0]  set_count;
      logic [15:0] day_rep_count;
      logic [15:0] day_set_count;
      logic [31:0] session_time;
      logic [31:0] day_time;
      logic        tracking_on;
   } state_type;

   typedef struct packed {
      logic        rep_done;
      logic [31:0] rep_duration_ms;
      logic [1:0]  pace;
      logic        set_done;
      logic [7:0]  reps_in_set;
      logic [7:0]  sets_done;
      logic        tracking;
      logic [31:0] session_active_ms;
      logic [15:0] daily_reps;
      logic [15:0] daily_sets;
      logic [31:0] daily_active_ms;
      logic        goal_reached;
   } result_type;

endpackage

[rtl/rhsc_step.sv]
// Next-state and result logic for one beat of the repetition and set counter.
module rhsc_step (
   input  rhsc_pkg::cfg_type    cfg,
   input  rhsc_pkg::state_type  cur,
   input  rhsc_pkg::item_type   item,
   output rhsc_pkg::state_type  nxt,
   output rhsc_pkg::result_type res
);

   always_comb begin
      logic        rep;
      logic        set;
      logic [31:0] dur;
      logic [1:0]  pace;

      nxt  = cur;
      rep  = 1'b0;
      set  = 1'b0;
      dur  = '0;
      pace = rhsc_pkg::PACE_OK;

      unique case (item.func)
         rhsc_pkg::FUNC_START: begin
            // A new session opens only when the current one is empty or complete.
            if (((cur.rep_count == '0) && (cur.set_count == '0)) ||
                (cur.set_count >= cfg.goal_sets)) begin
               nxt.rep_count    = '0;
               nxt.set_count    = '0;
               nxt.session_time = '0;
            end
            nxt.is_down     = 1'b0;
            nxt.down_time   = '0;
            nxt.tracking_on = 1'b1;
         end
         rhsc_pkg::FUNC_STOP: begin
            nxt.tracking_on = 1'b0;
            nxt.is_down     = 1'b0;
            nxt.down_time   = '0;
         end
         rhsc_pkg::FUNC_SAMPLE: begin
            if (cur.tracking_on && item.distance_valid && (item.distance != '0)) begin
               if (!cur.is_down && (item.distance < cfg.down_level)) begin
                  nxt.is_down   = 1'b1;
                  nxt.down_time = item.time_ms;
               end else if (cur.is_down && (item.distance > cfg.up_level)) begin
                  nxt.is_down = 1'b0;
                  rep         = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (rep) begin
         dur              = item.time_ms - cur.down_time;
         nxt.session_time = cur.session_time + dur;
         nxt.day_time     = cur.day_time + dur;
         if (cur.rep_count != rhsc_pkg::CNT8_MAX) begin
            nxt.rep_count = cur.rep_count + 8'd1;
         end
         if (cur.day_rep_count != rhsc_pkg::CNT16_MAX) begin
            nxt.day_rep_count = cur.day_rep_count + 16'd1;
         end
         priority if (dur < {16'd0, cfg.fast_limit_ms}) begin
            pace = rhsc_pkg::PACE_FAST;
         end else if (dur > {16'd0, cfg.slow_limit_ms}) begin
            pace = rhsc_pkg::PACE_SLOW;
         end else begin
            pace = rhsc_pkg::PACE_OK;
         end
         if (nxt.rep_count >= cfg.set_length) begin
            set           = 1'b1;
            nxt.rep_count = '0;
            if (cur.set_count != rhsc_pkg::CNT8_MAX) begin
               nxt.set_count = cur.set_count + 8'd1;
            end
            if (cur.day_set_count != rhsc_pkg::CNT16_MAX) begin
               nxt.day_set_count = cur.day_set_count + 16'd1;
            end
         end
      end

      res.rep_done          = rep;
      res.rep_duration_ms   = dur;
      res.pace              = pace;
      res.set_done          = set;
      res.reps_in_set       = nxt.rep_count;
      res.sets_done         = nxt.set_count;
      res.tracking          = nxt.tracking_on;
      res.session_active_ms = nxt.session_time;
      res.daily_reps        = nxt.day_rep_count;
      res.daily_sets        = nxt.day_set_count;
      res.daily_active_ms   = nxt.day_time;
      res.goal_reached      = (nxt.set_count >= cfg.goal_sets);
   end

endmodule

[rtl/hysteresis_rep_set_counter_core.sv]
// Top level of the hysteresis repetition and set counter.
//
//   Channel   Ports                Direction   Beat
//   request   req_valid/req_stall  in          one command or distance sample
//   response  rsp_valid/rsp_stall  out         one status result per request
//   csr       csr_write            in          one register write, no read-back
//
// Every request beat yields exactly one response beat. A beat is first held in
// an input register and is processed as it moves into the response register,
// so a new beat can be taken on every cycle while no response stall holds it.
// The response beat is driven from the response register.
// The rate of one beat per cycle is set by the combinational state update.
// A stalled response holds its register; the input register still takes one
// further beat before the request side is stalled.
// Synchronous active-high reset clears the counters, sums, motion state and
// the configuration registers to their defaults.
module hysteresis_rep_set_counter_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_distance,
   input  logic        req_distance_valid,
   input  logic [31:0] req_time_ms,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_rep_done,
   output logic [31:0] rsp_rep_duration_ms,
   output logic [1:0]  rsp_pace,
   output logic        rsp_set_done,
   output logic [7:0]  rsp_reps_in_set,
   output logic [7:0]  rsp_sets_done,
   output logic        rsp_tracking,
   output logic [31:0] rsp_session_active_ms,
   output logic [15:0] rsp_daily_reps,
   output logic [15:0] rsp_daily_sets,
   output logic [31:0] rsp_daily_active_ms,
   output logic        rsp_goal_reached,
   // configuration port
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   rhsc_pkg::cfg_type    cfg_ff;
   rhsc_pkg::state_type  state_ff;
   rhsc_pkg::state_type  state_in;
   rhsc_pkg::item_type   item_ff;
   rhsc_pkg::item_type   item_in;
   rhsc_pkg::result_type rsp_ff;
   rhsc_pkg::result_type rsp_in;
   logic                 item_valid_ff;
   logic                 item_valid_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 req_take;
   logic                 advance;

   // The held beat moves on whenever the response register is empty or drains.
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      item_in.func           = req_func;
      item_in.distance       = req_distance;
      item_in.distance_valid = req_distance_valid;
      item_in.time_ms        = req_time_ms;
   end

   rhsc_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Session and daily state changes only when a beat is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Configuration writes are taken at any time; writes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.down_level    <= rhsc_pkg::RST_DOWN_LEVEL;
         cfg_ff.up_level      <= rhsc_pkg::RST_UP_LEVEL;
         cfg_ff.fast_limit_ms <= rhsc_pkg::RST_FAST_LIMIT_MS;
         cfg_ff.slow_limit_ms <= rhsc_pkg::RST_SLOW_LIMIT_MS;
         cfg_ff.set_length    <= rhsc_pkg::RST_SET_LENGTH;
         cfg_ff.goal_sets     <= rhsc_pkg::RST_GOAL_SETS;
      end else if (csr_write) begin
         unique case (csr_index)
            rhsc_pkg::CSR_DOWN_LEVEL:    cfg_ff.down_level    <= csr_wdata;
            rhsc_pkg::CSR_UP_LEVEL:      cfg_ff.up_level      <= csr_wdata;
            rhsc_pkg::CSR_FAST_LIMIT_MS: cfg_ff.fast_limit_ms <= csr_wdata;
            rhsc_pkg::CSR_SLOW_LIMIT_MS: cfg_ff.slow_limit_ms <= csr_wdata;
            rhsc_pkg::CSR_SET_LENGTH:    cfg_ff.set_length    <= csr_wdata[7:0];
            rhsc_pkg::CSR_GOAL_SETS:     cfg_ff.goal_sets     <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_rep_done          = rsp_ff.rep_done;
   assign rsp_rep_duration_ms   = rsp_ff.rep_duration_ms;
   assign rsp_pace              = rsp_ff.pace;
   assign rsp_set_done          = rsp_ff.set_done;
   assign rsp_reps_in_set       = rsp_ff.reps_in_set;
   assign rsp_sets_done         = rsp_ff.sets_done;
   assign rsp_tracking          = rsp_ff.tracking;
   assign rsp_session_active_ms = rsp_ff.session_active_ms;
   assign rsp_daily_reps        = rsp_ff.daily_reps;
   assign rsp_daily_sets        = rsp_ff.daily_sets;
   assign rsp_daily_active_ms   = rsp_ff.daily_active_ms;
   assign rsp_goal_reached      = rsp_ff.goal_reached;

endmodule

[rtl/rhsc_checker.sv]
// Port-level checks for the repetition and set counter, bound to the top level.
module rhsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_rep_done,
   input logic [31:0] rsp_rep_duration_ms,
   input logic [1:0]  rsp_pace,
   input logic        rsp_set_done,
   input logic [7:0]  rsp_reps_in_set,
   input logic [15:0] rsp_daily_reps
);

   // A stalled response beat stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_daily_reps) &&
      $stable(rsp_rep_duration_ms))
      else $error("stalled response beat changed");

   // Without a repetition the per-repetition fields read zero.
   a_no_rep_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rep_done |->
      (rsp_rep_duration_ms == 32'd0) && (rsp_pace == rhsc_pkg::PACE_OK) && !rsp_set_done)
      else $error("repetition fields set without a repetition");

   // A finished set restarts the repetition count of the set.
   a_set_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_done |-> rsp_rep_done && (rsp_reps_in_set == 8'd0))
      else $error("set completed without repetition or with reps left");

   // The request side is stalled only while the response side is stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a response stall");

   // No response beat in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind hysteresis_rep_set_counter_core rhsc_checker u_rhsc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_rep_done        (rsp_rep_done),
   .rsp_rep_duration_ms (rsp_rep_duration_ms),
   .rsp_pace            (rsp_pace),
   .rsp_set_done        (rsp_set_done),
   .rsp_reps_in_set     (rsp_reps_in_set),
   .rsp_daily_reps      (rsp_daily_reps)
);
